FILE: design/othr_pkg.sv
package othr_pkg;

  localparam int CAPACITY = 1024;
  localparam int MAX_READ = 64;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int LIM_W = 7;
  localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int OFS_W = 64;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic             is_read;
    logic             none;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
    logic [LIM_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       none;
  } beat_t;

  function automatic logic [IDX_W-1:0] ring_wrap(logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= SUM_W'(CAPACITY)) ? s - SUM_W'(CAPACITY) : s;
    return r[IDX_W-1:0];
  endfunction

endpackage

FILE: design/othr_ram.sv
module othr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/othr_front.sv
module othr_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   operation_i,
  input  logic [7:0]                   data_byte_i,
  input  logic [othr_pkg::OFS_W-1:0]   from_offset_i,
  input  logic [othr_pkg::LIM_W-1:0]   read_max_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output othr_pkg::cmd_t               q_cmd_o
);

  logic [othr_pkg::IDX_W-1:0] oldest_q, oldest_d;
  logic [othr_pkg::CNT_W-1:0] held_q, held_d;
  logic [othr_pkg::OFS_W-1:0] total_q, total_d;
  logic [othr_pkg::OFS_W-1:0] base_q, base_d;

  logic                       accept;
  logic                       ring_full;
  logic                       sat;
  logic [othr_pkg::LIM_W-1:0] lim;
  logic                       none;
  logic [othr_pkg::CNT_W-1:0] skip;
  logic [othr_pkg::CNT_W-1:0] avail;
  logic [othr_pkg::LIM_W-1:0] n;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  always_comb begin
    ring_full = (held_q == othr_pkg::CNT_W'(othr_pkg::CAPACITY));
    sat       = (total_q == '1);
    lim       = (read_max_i > othr_pkg::LIM_W'(othr_pkg::MAX_READ)) ?
                othr_pkg::LIM_W'(othr_pkg::MAX_READ) : read_max_i;
    none      = (held_q == '0) || (lim == '0) || (from_offset_i >= total_q);
    skip      = (from_offset_i > base_q) ?
                from_offset_i[othr_pkg::CNT_W-1:0] - base_q[othr_pkg::CNT_W-1:0] : '0;
    avail     = held_q - skip;
    n         = (othr_pkg::CMP_W'(avail) < othr_pkg::CMP_W'(lim)) ?
                othr_pkg::LIM_W'(avail) : lim;

    q_cmd_o = '0;
    q_push_o = 1'b0;
    case (operation_i)
      othr_pkg::OP_APPEND: begin
        q_push_o        = accept;
        q_cmd_o.is_read = 1'b0;
        q_cmd_o.addr    = othr_pkg::ring_wrap(othr_pkg::SUM_W'(oldest_q) +
                                              othr_pkg::SUM_W'(held_q));
        q_cmd_o.data    = data_byte_i;
      end
      othr_pkg::OP_READ: begin
        q_push_o        = accept;
        q_cmd_o.is_read = 1'b1;
        q_cmd_o.none    = none;
        q_cmd_o.addr    = othr_pkg::ring_wrap(othr_pkg::SUM_W'(oldest_q) +
                                              othr_pkg::SUM_W'(skip));
        q_cmd_o.count   = none ? othr_pkg::LIM_W'(1) : n;
      end
      default: begin
        q_push_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    oldest_d = oldest_q;
    held_d   = held_q;
    total_d  = total_q;
    base_d   = base_q;
    if (accept) begin
      case (operation_i)
        othr_pkg::OP_APPEND: begin
          if (!sat) begin
            total_d = total_q + othr_pkg::OFS_W'(1);
          end
          if (ring_full) begin
            oldest_d = othr_pkg::ring_wrap(othr_pkg::SUM_W'(oldest_q) + othr_pkg::SUM_W'(1));
          end else begin
            held_d = held_q + othr_pkg::CNT_W'(1);
          end
          if (!sat && ring_full) begin
            base_d = base_q + othr_pkg::OFS_W'(1);
          end else if (sat && !ring_full) begin
            base_d = base_q - othr_pkg::OFS_W'(1);
          end
        end
        othr_pkg::OP_CLEAR: begin
          oldest_d = '0;
          held_d   = '0;
          total_d  = '0;
          base_d   = '0;
        end
        default: begin
          oldest_d = oldest_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      held_q   <= '0;
      total_q  <= '0;
      base_q   <= '0;
    end else begin
      oldest_q <= oldest_d;
      held_q   <= held_d;
      total_q  <= total_d;
      base_q   <= base_d;
    end
  end

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= othr_pkg::CNT_W'(othr_pkg::CAPACITY))
    else $error("held count above capacity");

  a_base_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q + othr_pkg::OFS_W'(held_q) == total_q)
    else $error("base offset out of step with total");

endmodule

FILE: design/othr_queue.sv
module othr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  othr_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output othr_pkg::cmd_t cmd_o
);

  othr_pkg::cmd_t              slot_q [othr_pkg::QDEPTH];
  logic [othr_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [othr_pkg::QPTR_W:0]   count_q;

  assign full_o  = (count_q == (othr_pkg::QPTR_W + 1)'(othr_pkg::QDEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + othr_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + othr_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (othr_pkg::QPTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (othr_pkg::QPTR_W + 1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue underflow");

endmodule

FILE: design/othr_back.sv
module othr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  othr_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           last_o,
  output logic           none_available_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                       state_q, state_d;
  logic [othr_pkg::IDX_W-1:0] rd_addr_q, rd_addr_d;
  logic [othr_pkg::LIM_W-1:0] left_q, left_d;
  logic                       none_q, none_d;
  logic                       pend_q, pend_d;
  logic                       pend_last_q, pend_last_d;
  logic                       pend_none_q, pend_none_d;

  othr_pkg::beat_t            head_q, skid_q, arrive;
  logic                       hv_q, sv_q;

  logic                       ram_we, ram_re;
  logic [7:0]                 ram_rdata;
  logic                       pop_out;
  logic [1:0]                 used;
  logic                       can_issue;

  othr_ram #(
    .WIDTH (8),
    .DEPTH (othr_pkg::CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (q_cmd_i.addr),
    .wdata_i (q_cmd_i.data),
    .re_i    (ram_re),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  assign pop_out   = hv_q && !out_stall_i;
  assign used      = 2'(hv_q) + 2'(sv_q) + 2'(pend_q) - 2'(pop_out);
  assign can_issue = (used < 2'd2);

  always_comb begin
    state_d     = state_q;
    rd_addr_d   = rd_addr_q;
    left_d      = left_q;
    none_d      = none_q;
    pend_d      = 1'b0;
    pend_last_d = pend_last_q;
    pend_none_d = pend_none_q;
    q_pop_o     = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.is_read) begin
            rd_addr_d = q_cmd_i.addr;
            left_d    = q_cmd_i.count;
            none_d    = q_cmd_i.none;
            state_d   = ST_READ;
          end else begin
            ram_we = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (can_issue) begin
          ram_re      = 1'b1;
          pend_d      = 1'b1;
          pend_last_d = (left_q == othr_pkg::LIM_W'(1));
          pend_none_d = none_q;
          rd_addr_d   = othr_pkg::ring_wrap(othr_pkg::SUM_W'(rd_addr_q) +
                                            othr_pkg::SUM_W'(1));
          left_d      = left_q - othr_pkg::LIM_W'(1);
          if (left_q == othr_pkg::LIM_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    arrive.out_byte = pend_none_q ? 8'd0 : ram_rdata;
    arrive.last     = pend_last_q;
    arrive.none     = pend_none_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      left_q      <= '0;
      pend_q      <= 1'b0;
      hv_q        <= 1'b0;
      sv_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      left_q  <= left_d;
      pend_q  <= pend_d;
      if (pop_out) begin
        hv_q <= sv_q || pend_q;
        sv_q <= sv_q && pend_q;
      end else if (pend_q) begin
        hv_q <= 1'b1;
        sv_q <= hv_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q   <= rd_addr_d;
    none_q      <= none_d;
    pend_last_q <= pend_last_d;
    pend_none_q <= pend_none_d;
    if (pop_out) begin
      head_q <= sv_q ? skid_q : arrive;
      if (sv_q) begin
        skid_q <= arrive;
      end
    end else if (pend_q) begin
      if (hv_q) begin
        skid_q <= arrive;
      end else begin
        head_q <= arrive;
      end
    end
  end

  assign out_valid_o      = hv_q;
  assign out_byte_o       = head_q.out_byte;
  assign last_o           = head_q.last;
  assign none_available_o = head_q.none;

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> hv_q)
    else $error("skid beat held without head beat");

  a_slot_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hv_q && sv_q && pend_q))
    else $error("read issued without room for its beat");

  a_read_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> left_q != '0)
    else $error("read burst with nothing left");

endmodule

FILE: design/offset_tracked_history_ring_top.sv
// Commands are taken one per cycle while the command queue has room. A read's first
// beat passes the queue, read state, RAM read register and output stage; bytes follow
// one per cycle unless the output stalls; the back end pops no command until its bytes
// are all issued. A two-entry output stage absorbs stalls without losing the rate.
// Reset clears ring pointers, stream offset, queue and output stage at once;
// the history memory is not cleared and needs no sweep.
module offset_tracked_history_ring_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 operation_i,
  input  logic [7:0]                 data_byte_i,
  input  logic [othr_pkg::OFS_W-1:0] from_offset_i,
  input  logic [othr_pkg::LIM_W-1:0] read_max_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic                       last_o,
  output logic                       none_available_o
);

  logic           q_full;
  logic           q_push;
  othr_pkg::cmd_t q_cmd_in;
  logic           q_pop;
  logic           q_valid;
  othr_pkg::cmd_t q_cmd_out;

  othr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .data_byte_i   (data_byte_i),
    .from_offset_i (from_offset_i),
    .read_max_i    (read_max_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (q_cmd_in)
  );

  othr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd_out)
  );

  othr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_cmd_i          (q_cmd_out),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .last_o           (last_o),
    .none_available_o (none_available_o)
  );

endmodule

FILE: verif/offset_tracked_history_ring_top_test.sv
`timescale 1ns / 1ps

module offset_tracked_history_ring_top_test;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned TAIL_CYCLES = 20;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           in_valid_i    = 1'b0;
  logic                           in_stall_o;
  logic [1:0]                     operation_i   = othr_pkg::OP_APPEND;
  logic [7:0]                     data_byte_i   = 8'd0;
  logic [othr_pkg::OFS_W-1:0]     from_offset_i = '0;
  logic [othr_pkg::LIM_W-1:0]     read_max_i    = '0;
  logic                           out_valid_o;
  logic                           out_stall_i   = 1'b0;
  logic [7:0]                     out_byte_o;
  logic                           last_o;
  logic                           none_available_o;

  logic [7:0]                     hist_mem [othr_pkg::CAPACITY];
  logic [othr_pkg::IDX_W-1:0]     head_idx    = '0;
  logic [othr_pkg::CNT_W-1:0]     kept_count  = '0;
  logic [othr_pkg::OFS_W-1:0]     stream_pos  = '0;

  othr_pkg::beat_t                beats_due [$];
  othr_pkg::beat_t                want;
  int                             mismatch_count = 0;

  bit                             idle_on   = 1'b1;
  int                             hold_len  = 0;
  int                             hold_seq  = 0;
  int                             hold_seen = 0;
  int                             hold_left = 0;

  offset_tracked_history_ring_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .data_byte_i      (data_byte_i),
    .from_offset_i    (from_offset_i),
    .read_max_i       (read_max_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .last_o           (last_o),
    .none_available_o (none_available_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [othr_pkg::IDX_W-1:0] idx_step(logic [othr_pkg::IDX_W-1:0] pos,
                                                          int unsigned n);
    return othr_pkg::IDX_W'((int'(pos) + n) % othr_pkg::CAPACITY);
  endfunction

  function automatic void ring_update(logic [1:0] op, logic [7:0] b,
                                      logic [othr_pkg::OFS_W-1:0] start_ofs,
                                      logic [othr_pkg::LIM_W-1:0] max_cnt);
    logic [othr_pkg::OFS_W-1:0] base;
    logic [othr_pkg::OFS_W-1:0] gap;
    int unsigned                lim;
    int unsigned                skip;
    int unsigned                avail;
    int unsigned                n;
    logic [othr_pkg::IDX_W-1:0] pos;
    case (op)
      othr_pkg::OP_APPEND: begin
        if (stream_pos != '1) stream_pos = stream_pos + othr_pkg::OFS_W'(1);
        if (kept_count >= othr_pkg::CNT_W'(othr_pkg::CAPACITY)) begin
          head_idx   = idx_step(head_idx, 1);
          kept_count = othr_pkg::CNT_W'(othr_pkg::CAPACITY - 1);
        end
        pos = idx_step(head_idx, kept_count);
        hist_mem[pos] = b;
        kept_count = kept_count + othr_pkg::CNT_W'(1);
      end
      othr_pkg::OP_CLEAR: begin
        head_idx   = '0;
        kept_count = '0;
        stream_pos = '0;
      end
      othr_pkg::OP_READ: begin
        lim = (max_cnt > othr_pkg::LIM_W'(othr_pkg::MAX_READ)) ? othr_pkg::MAX_READ : max_cnt;
        if (kept_count == 0 || lim == 0 || start_ofs >= stream_pos) begin
          beats_due.push_back(othr_pkg::beat_t'{out_byte: 8'd0, last: 1'b1, none: 1'b1});
          return;
        end
        base = stream_pos - othr_pkg::OFS_W'(kept_count);
        if (start_ofs <= base) begin
          skip = 0;
        end else begin
          gap = start_ofs - base;
          if (gap >= othr_pkg::OFS_W'(kept_count)) begin
            beats_due.push_back(othr_pkg::beat_t'{out_byte: 8'd0, last: 1'b1, none: 1'b1});
            return;
          end
          skip = int'(gap);
        end
        avail = kept_count - skip;
        n     = (avail < lim) ? avail : lim;
        pos   = idx_step(head_idx, skip);
        for (int unsigned k = 0; k < n; k++) begin
          beats_due.push_back(othr_pkg::beat_t'{out_byte: hist_mem[pos], last: (k + 1 == n),
                                                none: 1'b0});
          pos = idx_step(pos, 1);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic push_item(logic [1:0] op, logic [7:0] b,
                           logic [othr_pkg::OFS_W-1:0] start_ofs,
                           logic [othr_pkg::LIM_W-1:0] max_cnt);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    data_byte_i   <= b;
    from_offset_i <= start_ofs;
    read_max_i    <= max_cnt;
    do @(posedge clk_i); while (in_stall_o);
    ring_update(op, b, start_ofs, max_cnt);
  endtask

  task automatic rest_input;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain_beats;
    rest_input();
    while (beats_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [othr_pkg::OFS_W-1:0] rand_ofs;
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed;
    push_item(othr_pkg::OP_READ, 8'h3C, 64'd0, 7'd64);
    push_item(OP_UNUSED, 8'hFF, '1, '1);
    push_item(othr_pkg::OP_APPEND, 8'h00, rand_ofs(), 7'd0);
    push_item(othr_pkg::OP_APPEND, 8'hFF, rand_ofs(), 7'd127);
    push_item(othr_pkg::OP_APPEND, 8'hA5, rand_ofs(), 7'd1);
    push_item(othr_pkg::OP_READ, 8'h00, 64'd0, 7'd64);
    push_item(othr_pkg::OP_READ, 8'hFF, 64'd0, 7'd0);
    push_item(othr_pkg::OP_READ, 8'h00, 64'd0, 7'd127);
    push_item(othr_pkg::OP_READ, 8'h00, 64'd0, 7'd1);
    push_item(othr_pkg::OP_READ, 8'h00, 64'd1, 7'd64);
    push_item(othr_pkg::OP_READ, 8'h00, 64'd2, 7'd65);
    push_item(othr_pkg::OP_READ, 8'h00, 64'd3, 7'd64);
    push_item(othr_pkg::OP_READ, 8'h00, '1, 7'd64);
    push_item(othr_pkg::OP_READ, 8'h00, 64'h8000_0000_0000_0000, 7'd64);
    push_item(othr_pkg::OP_CLEAR, 8'h55, rand_ofs(), 7'd64);
    push_item(othr_pkg::OP_READ, 8'h00, 64'd0, 7'd64);
    push_item(OP_UNUSED, 8'($urandom), rand_ofs(), othr_pkg::LIM_W'($urandom));
    push_item(othr_pkg::OP_APPEND, 8'h5A, 64'd0, 7'd64);
    push_item(othr_pkg::OP_READ, 8'h00, 64'd0, 7'd64);
    drain_beats();
  endtask

  task automatic test_wrap;
    logic [othr_pkg::OFS_W-1:0] base;
    for (int i = 0; i < othr_pkg::CAPACITY + 40; i++) begin
      push_item(othr_pkg::OP_APPEND, 8'($urandom), rand_ofs(), othr_pkg::LIM_W'($urandom));
    end
    base = stream_pos - othr_pkg::OFS_W'(kept_count);
    push_item(othr_pkg::OP_READ, 8'($urandom), 64'd0, 7'd64);
    push_item(othr_pkg::OP_READ, 8'($urandom), base - 1, 7'd64);
    push_item(othr_pkg::OP_READ, 8'($urandom), base, 7'd5);
    push_item(othr_pkg::OP_READ, 8'($urandom), base + 1, 7'd64);
    push_item(othr_pkg::OP_READ, 8'($urandom), stream_pos - 64, 7'd64);
    push_item(othr_pkg::OP_READ, 8'($urandom), stream_pos - 1, 7'd64);
    push_item(othr_pkg::OP_READ, 8'($urandom), stream_pos, 7'd64);
    push_item(othr_pkg::OP_APPEND, 8'hC3, rand_ofs(), 7'd0);
    push_item(othr_pkg::OP_APPEND, 8'h3C, rand_ofs(), 7'd0);
    push_item(othr_pkg::OP_READ, 8'($urandom), stream_pos - 10, 7'd64);
    drain_beats();
  endtask

  task automatic test_backpressure;
    hold_len = 400;
    hold_seq++;
    for (int i = 0; i < 16; i++) begin
      push_item(othr_pkg::OP_READ, 8'($urandom),
                stream_pos - othr_pkg::OFS_W'(kept_count) +
                othr_pkg::OFS_W'($urandom_range(0, 200)), 7'd64);
    end
    drain_beats();
  endtask

  task automatic test_random;
    int unsigned                pick;
    logic [1:0]                 op;
    logic [othr_pkg::OFS_W-1:0] start_ofs;
    logic [othr_pkg::LIM_W-1:0] max_cnt;
    int                         sent;
    sent = 0;
    while (sent < 250) begin
      idle_on = !(sent >= 100 && sent < 160);
      pick = $urandom_range(99);
      if (pick < 48)      op = othr_pkg::OP_APPEND;
      else if (pick < 91) op = othr_pkg::OP_READ;
      else if (pick < 96) op = othr_pkg::OP_CLEAR;
      else                op = OP_UNUSED;
      pick = $urandom_range(99);
      if (pick < 10) begin
        start_ofs = rand_ofs();
      end else if (pick < 13) begin
        start_ofs = '1;
      end else begin
        start_ofs = stream_pos - othr_pkg::OFS_W'(kept_count) +
                    othr_pkg::OFS_W'($urandom_range(0, kept_count + 8));
        start_ofs = (start_ofs >= 4) ? start_ofs - 4 : '0;
      end
      pick = $urandom_range(99);
      if (pick < 5)       max_cnt = 7'd0;
      else if (pick < 12) max_cnt = othr_pkg::LIM_W'($urandom_range(65, 127));
      else                max_cnt = othr_pkg::LIM_W'($urandom_range(1, 64));
      push_item(op, 8'($urandom), start_ofs, max_cnt);
      if (op != OP_UNUSED) sent++;
    end
    idle_on = 1'b1;
    drain_beats();
  endtask

  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(99) < 15);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (beats_due.size() == 0) begin
        $error("unexpected beat: out_byte %0h last %0b none_available %0b",
               out_byte_o, last_o, none_available_o);
        mismatch_count++;
      end else begin
        want = beats_due.pop_front();
        if (out_byte_o !== want.out_byte) begin
          $error("out_byte: expected %0h, actual %0h", want.out_byte, out_byte_o);
          mismatch_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, last_o);
          mismatch_count++;
        end
        if (none_available_o !== want.none) begin
          $error("none_available: expected %0b, actual %0b", want.none, none_available_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL offset_tracked_history_ring_top");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_wrap();
    test_backpressure();
    test_random();
    drain_beats();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && beats_due.size() == 0) begin
      $display("PASS offset_tracked_history_ring_top");
    end else begin
      $display("FAIL offset_tracked_history_ring_top");
    end
    $finish;
  end

endmodule
